// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds in the same cycle
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition holds in the following cycle
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the two-level cache lookup.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int TAG_W      = 32;
  localparam int L1_AGE_W   = 3;
  localparam int L2_AGE_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_L1_SET_BITS = 3'd0,
    CFG_L1_OFF_BITS = 3'd1,
    CFG_L1_WAYS     = 3'd2,
    CFG_L2_SET_BITS = 3'd3,
    CFG_L2_OFF_BITS = 3'd4,
    CFG_L2_WAYS     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LVL_L1   = 2'd0,
    LVL_L2   = 2'd1,
    LVL_MISS = 2'd2
  } hit_level_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_POST
  } state_t;

  // controller -> level datapath
  typedef struct packed {
    logic load;   // capture address
    logic rd;     // read set row
    logic wr;     // write updated row back
    logic fill;   // allocate on miss
  } lvl_cmd_t;

  // level datapath -> controller
  typedef struct packed {
    logic hit;
  } lvl_stat_t;

endpackage

// ===== sv/tlc_level.sv =====
// ----------------------------------------------------------------------------
// tlc_level
// Tag, valid and age store of one cache level with its lookup/update logic.
// ----------------------------------------------------------------------------
module tlc_level #(
  parameter int WAYS_MAX  = 4,
  parameter int SETS_MAX  = 64,
  parameter int AGE_W     = 3,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ADDR_BITS-1:0]  addr,
  input  logic [3:0]            set_bits,
  input  logic [3:0]            off_bits,
  input  logic [3:0]            ways,
  input  tlc_pkg::lvl_cmd_t     cmd,
  output tlc_pkg::lvl_stat_t    stat
);
  import tlc_pkg::*;

  localparam int SB_MAX = $clog2(SETS_MAX + 1) - 1;
  localparam int SET_W  = (SETS_MAX > 1) ? $clog2(SETS_MAX) : 1;
  localparam int WAY_W  = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int K_W    = $clog2(WAYS_MAX + 1);

  logic [WAYS_MAX-1:0][TAG_W-1:0] tag_mem [SETS_MAX];
  logic [WAYS_MAX-1:0]            vld_mem [SETS_MAX];
  logic [WAYS_MAX-1:0][AGE_W-1:0] age_mem [SETS_MAX];
  logic [SETS_MAX-1:0]            row_init_r;

  logic [ADDR_BITS-1:0]           addr_r;
  logic [SET_W-1:0]               set_r;
  logic [TAG_W-1:0]               tag_r;
  logic                           init_r;
  logic [WAYS_MAX-1:0][TAG_W-1:0] t_r;
  logic [WAYS_MAX-1:0]            v_r;
  logic [WAYS_MAX-1:0][AGE_W-1:0] a_r;

  logic [3:0]                     sb;
  logic [4:0]                     k5;
  logic [K_W-1:0]                 k;
  logic [4:0]                     tsh;
  logic [ADDR_BITS-1:0]           mask;
  logic [SET_W-1:0]               set_c;
  logic [TAG_W-1:0]               tag_c;

  logic [WAYS_MAX-1:0]            use_w;
  logic [WAYS_MAX-1:0]            v;
  logic [WAYS_MAX-1:0][AGE_W-1:0] a;
  logic                           hit;
  logic [WAY_W-1:0]               hit_idx;
  logic [AGE_W-1:0]               hit_age;
  logic                           inv;
  logic [WAY_W-1:0]               inv_idx;
  logic                           evict;
  logic [WAYS_MAX-1:0][TAG_W-1:0] n_t;
  logic [WAYS_MAX-1:0]            n_v;
  logic [WAYS_MAX-1:0][AGE_W-1:0] n_a;

  // address split with the current configuration
  always_comb begin
    sb = (set_bits > 4'(SB_MAX)) ? 4'(SB_MAX) : set_bits;
    if (ways == 4'd0)
      k5 = 5'd1;
    else if ({1'b0, ways} > 5'(WAYS_MAX))
      k5 = 5'(WAYS_MAX);
    else
      k5 = {1'b0, ways};
    k     = K_W'(k5);
    tsh   = 5'(off_bits) + 5'(sb);
    mask  = ~({ADDR_BITS{1'b1}} << sb);
    set_c = SET_W'((addr_r >> off_bits) & mask);
    tag_c = TAG_W'(addr_r >> tsh);
  end

  function automatic logic [AGE_W-1:0] bump(input logic [AGE_W-1:0] x);
    return (x != {AGE_W{1'b1}}) ? x + AGE_W'(1) : x;
  endfunction

  // lookup and replacement on the row read last cycle
  always_comb begin
    for (int w = 0; w < WAYS_MAX; w++)
      use_w[w] = (K_W'(w) < k);
    v = init_r ? v_r : '0;
    a = init_r ? a_r : '0;

    hit = 1'b0;
    hit_idx = '0;
    inv = 1'b0;
    inv_idx = '0;
    for (int w = 0; w < WAYS_MAX; w++) begin
      if (!hit && use_w[w] && v[w] && (t_r[w] == tag_r)) begin
        hit = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!inv && use_w[w] && !v[w]) begin
        inv = 1'b1;
        inv_idx = WAY_W'(w);
      end
    end
    hit_age = a[hit_idx];

    n_t = t_r;
    n_v = v;
    n_a = a;
    evict = 1'b0;
    if (hit) begin
      for (int w = 0; w < WAYS_MAX; w++)
        if (use_w[w] && v[w] && (a[w] < hit_age))
          n_a[w] = bump(a[w]);
      n_a[hit_idx] = '0;
    end else if (cmd.fill) begin
      if (inv) begin
        for (int w = 0; w < WAYS_MAX; w++)
          if (use_w[w] && v[w])
            n_a[w] = bump(a[w]);
        n_t[inv_idx] = tag_r;
        n_v[inv_idx] = 1'b1;
        n_a[inv_idx] = '0;
      end else begin
        // full set: age everything, replace first aged-out way
        for (int w = 0; w < WAYS_MAX; w++)
          if (use_w[w])
            n_a[w] = bump(a[w]);
        for (int w = 0; w < WAYS_MAX; w++) begin
          if (!evict && use_w[w] && (6'(n_a[w]) >= 6'(k))) begin
            evict = 1'b1;
            n_t[w] = tag_r;
            n_a[w] = '0;
          end
        end
      end
    end
    stat.hit = hit;
  end

  always_ff @(posedge clk) begin
    if (cmd.load)
      addr_r <= addr;
    if (cmd.rd) begin
      set_r  <= set_c;
      tag_r  <= tag_c;
      init_r <= row_init_r[set_c];
      t_r    <= tag_mem[set_c];
      v_r    <= vld_mem[set_c];
      a_r    <= age_mem[set_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      tag_mem[set_r] <= n_t;
      vld_mem[set_r] <= n_v;
      age_mem[set_r] <= n_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      row_init_r <= '0;
    else if (cmd.wr)
      row_init_r[set_r] <= 1'b1;
  end

endmodule

// ===== sv/tlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlc_ctrl
// Sequencer for one lookup and the result word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_hit_level,
  output tlc_pkg::lvl_cmd_t  l1_cmd,
  output tlc_pkg::lvl_cmd_t  l2_cmd,
  input  tlc_pkg::lvl_stat_t l1_stat,
  input  tlc_pkg::lvl_stat_t l2_stat
);
  import tlc_pkg::*;

  state_t     state_r, state_nxt;
  hit_level_t lvl_r, lvl_nxt;
  logic       out_valid_r, out_valid_nxt;
  hit_level_t out_lvl_r, out_lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    out_lvl_r <= out_lvl_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    out_lvl_nxt   = out_lvl_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    l1_cmd        = '0;
    l2_cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          l1_cmd.load = 1'b1;
          l2_cmd.load = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        l1_cmd.rd = 1'b1;
        l2_cmd.rd = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        l1_cmd.wr = 1'b1;
        if (l1_stat.hit) begin
          lvl_nxt = LVL_L1;
        end else begin
          l1_cmd.fill = 1'b1;
          l2_cmd.wr   = 1'b1;
          l2_cmd.fill = 1'b1;
          lvl_nxt     = l2_stat.hit ? LVL_L2 : LVL_MISS;
        end
        state_nxt = S_POST;
      end
      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_lvl_nxt   = lvl_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_hit_level = out_lvl_r;

  `ASSERT_NXT(a_accept_reads, clk, rst_n, in_valid && !in_stall, state_r == S_READ)
  `ASSERT_IMP(a_write_in_update, clk, rst_n, l1_cmd.wr || l2_cmd.wr, state_r == S_UPDATE)
  `ASSERT_IMP(a_l2_only_on_miss, clk, rst_n, l2_cmd.wr, l1_cmd.wr && !l1_stat.hit)

endmodule

// ===== sv/two_level_cache_lru_lookup.sv =====
// ----------------------------------------------------------------------------
// two_level_cache_lru_lookup
// Two-level set-associative tag lookup with age-based LRU replacement.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel: one byte address per word (in_valid/in_stall). A word is
//    taken when in_valid is high and in_stall low.
//  - Output channel: one hit level per address (out_valid/out_stall):
//    0 = level one hit, 1 = level two hit, 2 = missed both.
//  - Config channel: cfg_valid/cfg_ready, always ready; cfg_index selects
//    the register, unknown indexes are ignored. Write only while idle.
//  - Steps per address: accept, row read of both tag stores, combined
//    update/write-back, result load. Set by the single-port read-modify-write
//    of each level's row memory; the next address is taken after the load.
//  - Stall: the result sits in an output register; the next address is
//    taken meanwhile, and its result waits in the sequencer until the
//    register frees.
//  - Reset: per-row init flags clear, so every way reads invalid with age
//    zero; no clearing sweep is needed. Config returns to its defaults.
// ----------------------------------------------------------------------------
module two_level_cache_lru_lookup #(
  parameter int L1_SETS_MAX = 64,
  parameter int L1_WAYS_MAX = 4,
  parameter int L2_SETS_MAX = 256,
  parameter int L2_WAYS_MAX = 8,
  parameter int ADDR_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ADDR_BITS-1:0]           in_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_hit_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlc_pkg::*;

  // configuration registers
  logic [2:0] l1_set_bits_r;
  logic [3:0] l1_off_bits_r;
  logic [2:0] l1_ways_r;
  logic [3:0] l2_set_bits_r;
  logic [3:0] l2_off_bits_r;
  logic [3:0] l2_ways_r;

  lvl_cmd_t  l1_cmd, l2_cmd;
  lvl_stat_t l1_stat, l2_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_set_bits_r <= 3'd6;
      l1_off_bits_r <= 4'd4;
      l1_ways_r     <= 3'd4;
      l2_set_bits_r <= 4'd8;
      l2_off_bits_r <= 4'd6;
      l2_ways_r     <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_L1_SET_BITS: l1_set_bits_r <= cfg_data[2:0];
        CFG_L1_OFF_BITS: l1_off_bits_r <= cfg_data;
        CFG_L1_WAYS:     l1_ways_r     <= cfg_data[2:0];
        CFG_L2_SET_BITS: l2_set_bits_r <= cfg_data;
        CFG_L2_OFF_BITS: l2_off_bits_r <= cfg_data;
        CFG_L2_WAYS:     l2_ways_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: owns the handshakes and decides which level writes back
  tlc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit_level (out_hit_level),
    .l1_cmd        (l1_cmd),
    .l2_cmd        (l2_cmd),
    .l1_stat       (l1_stat),
    .l2_stat       (l2_stat)
  );

  // level one: searched first, filled on any level one miss
  tlc_level #(
    .WAYS_MAX  (L1_WAYS_MAX),
    .SETS_MAX  (L1_SETS_MAX),
    .AGE_W     (L1_AGE_W),
    .ADDR_BITS (ADDR_BITS)
  ) u_l1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (in_address),
    .set_bits ({1'b0, l1_set_bits_r}),
    .off_bits (l1_off_bits_r),
    .ways     ({1'b0, l1_ways_r}),
    .cmd      (l1_cmd),
    .stat     (l1_stat)
  );

  // level two: read alongside level one, written only on a level one miss
  tlc_level #(
    .WAYS_MAX  (L2_WAYS_MAX),
    .SETS_MAX  (L2_SETS_MAX),
    .AGE_W     (L2_AGE_W),
    .ADDR_BITS (ADDR_BITS)
  ) u_l2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (in_address),
    .set_bits (l2_set_bits_r),
    .off_bits (l2_off_bits_r),
    .ways     (l2_ways_r),
    .cmd      (l2_cmd),
    .stat     (l2_stat)
  );

endmodule
